@@ rtl/core/usb_charger_detect_fsm_defines.svh @@
// Assertion helpers shared by the charger detection RTL.
// They expect signals named clk and arst_n in the module that uses them.
`ifndef USB_CHARGER_DETECT_FSM_DEFINES_SVH
`define USB_CHARGER_DETECT_FSM_DEFINES_SVH

// same-cycle implication
`define UCD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UCD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ucd_pkg.sv @@
`default_nettype none

package ucd_pkg;

	// request modes
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_START = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// charger kinds
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_SDP  = 2'd1;
	localparam logic [1:0] KIND_DCP  = 2'd2;
	localparam logic [1:0] KIND_CDP  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_CONTACT_POLL   = 2'd0;
	localparam logic [1:0] REG_PRIMARY_WAIT   = 2'd1;
	localparam logic [1:0] REG_SECONDARY_WAIT = 2'd2;
	localparam logic [1:0] REG_CONTACT_RETRY  = 2'd3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_CONTACT,
		PH_PRIMARY,
		PH_SECONDARY,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [15:0] contact_poll_ticks;
		logic [15:0] primary_wait_ticks;
		logic [15:0] secondary_wait_ticks;
		logic [7:0]  contact_max_retries;
	} cfg_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       contact_seen;
		logic       primary_seen;
		logic       secondary_seen;
	} item_t;

	typedef struct packed {
		logic secondary;
		logic primary;
		logic contact;
		logic normal;
	} enables_t;

	typedef struct packed {
		enables_t   en;
		logic [1:0] charger_kind;
		logic       detect_done;
		logic       busy_res;
	} result_t;

	localparam enables_t EN_IDLE      = '{secondary: 1'b0, primary: 1'b0, contact: 1'b0,
		normal: 1'b1};
	localparam enables_t EN_CONTACT   = '{secondary: 1'b0, primary: 1'b0, contact: 1'b1,
		normal: 1'b0};
	localparam enables_t EN_PRIMARY   = '{secondary: 1'b0, primary: 1'b1, contact: 1'b0,
		normal: 1'b0};
	localparam enables_t EN_SECONDARY = '{secondary: 1'b1, primary: 1'b0, contact: 1'b0,
		normal: 1'b0};

endpackage

`default_nettype wire

@@ rtl/core/ucd_cfg_regs.sv @@
`default_nettype none

module ucd_cfg_regs
	import ucd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.contact_poll_ticks   <= 16'd10;
			cfg_q.primary_wait_ticks   <= 16'd40;
			cfg_q.secondary_wait_ticks <= 16'd40;
			cfg_q.contact_max_retries  <= 8'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTACT_POLL:   cfg_q.contact_poll_ticks   <= cfg_wdata;
				REG_PRIMARY_WAIT:   cfg_q.primary_wait_ticks   <= cfg_wdata;
				REG_SECONDARY_WAIT: cfg_q.secondary_wait_ticks <= cfg_wdata;
				REG_CONTACT_RETRY:  cfg_q.contact_max_retries  <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/core/ucd_seq.sv @@
`default_nettype none

`include "usb_charger_detect_fsm_defines.svh"

module ucd_seq
	import ucd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  step,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	phase_t     phase_q, phase_d;
	logic [7:0] poll_q, poll_d;
	logic [15:0] wait_q, wait_d;
	logic [1:0] kind_q, kind_d;
	enables_t   en_q, en_d;
	logic       done_d;
	logic [7:0] poll_inc;
	logic       busy_q;

	assign busy_q   = (phase_q == PH_CONTACT) || (phase_q == PH_PRIMARY) ||
		(phase_q == PH_SECONDARY);
	assign poll_inc = poll_q + 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			poll_q  <= '0;
			wait_q  <= '0;
			kind_q  <= KIND_NONE;
			en_q    <= EN_IDLE;
		end else if (step) begin
			phase_q <= phase_d;
			poll_q  <= poll_d;
			wait_q  <= wait_d;
			kind_q  <= kind_d;
			en_q    <= en_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		poll_d  = poll_q;
		wait_d  = wait_q;
		kind_d  = kind_q;
		en_d    = en_q;
		done_d  = 1'b0;
		unique case (item.mode)
			MODE_START: begin
				if (phase_q == PH_IDLE) begin
					kind_d  = KIND_NONE;
					en_d    = EN_CONTACT;
					poll_d  = '0;
					wait_d  = cfg.contact_poll_ticks;
					phase_d = PH_CONTACT;
				end
			end
			MODE_CLEAR: begin
				phase_d = PH_IDLE;
				poll_d  = '0;
				wait_d  = '0;
				kind_d  = KIND_NONE;
				en_d    = EN_IDLE;
			end
			MODE_TICK: begin
				if (busy_q) begin
					if (wait_q > 16'd1) begin
						wait_d = wait_q - 16'd1;
					end else begin
						wait_d = '0;
						unique case (phase_q)
							PH_CONTACT: begin
								poll_d = poll_inc;
								if (item.contact_seen ||
									(poll_inc == cfg.contact_max_retries)) begin
									en_d    = EN_PRIMARY;
									wait_d  = cfg.primary_wait_ticks;
									phase_d = PH_PRIMARY;
								end else begin
									wait_d = cfg.contact_poll_ticks;
								end
							end
							PH_PRIMARY: begin
								if (item.primary_seen) begin
									en_d    = EN_SECONDARY;
									wait_d  = cfg.secondary_wait_ticks;
									phase_d = PH_SECONDARY;
								end else begin
									// floating line: retries exhausted without contact
									kind_d  = (poll_q == cfg.contact_max_retries) ?
										KIND_DCP : KIND_SDP;
									en_d    = EN_IDLE;
									phase_d = PH_DONE;
									done_d  = 1'b1;
								end
							end
							PH_SECONDARY: begin
								kind_d  = item.secondary_seen ? KIND_DCP : KIND_CDP;
								en_d    = EN_IDLE;
								phase_d = PH_DONE;
								done_d  = 1'b1;
							end
							default: ;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		res.en           = en_d;
		res.charger_kind = kind_d;
		res.detect_done  = done_d;
		res.busy_res     = (phase_d == PH_CONTACT) || (phase_d == PH_PRIMARY) ||
			(phase_d == PH_SECONDARY);
	end

	`UCD_ASSERT_NOW(a_done_has_kind, phase_q == PH_DONE, kind_q != KIND_NONE,
		"finished sequence without a charger kind")
	`UCD_ASSERT_NOW(a_busy_not_normal, busy_q, !en_q.normal,
		"PHY in normal mode during detection")
	`UCD_ASSERT_NEXT(a_start_enters_contact,
		step && (item.mode == MODE_START) && (phase_q == PH_IDLE),
		(phase_q == PH_CONTACT) && (poll_q == 8'd0),
		"start from idle did not open contact phase")

endmodule

`default_nettype wire

@@ rtl/core/usb_charger_detect_fsm.sv @@
// Charger detection sequencer for a USB PHY. Each request carries a mode (tick, start,
// clear) and the three comparator levels; each request yields exactly one result with
// the PHY enables, the charger kind, a done pulse and a busy flag, all as they stand
// after that request. A request passes an input register, then the step logic and a
// result register: its result is offered once the result register holds it, which a
// full, stalled result register delays; one request per cycle is sustained as long
// as the result side keeps up. Up to two requests are held (one in each register);
// the input stalls only while both are full and the result is stalled. Wait counts
// and retry limit come from the configuration port (indexes 0..3: contact poll
// ticks, primary wait ticks, secondary wait ticks, contact retries); write them
// only while no request is in flight.
`default_nettype none

`include "usb_charger_detect_fsm_defines.svh"

module usb_charger_detect_fsm
	import ucd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [1:0]            mode,
	input  wire logic                  contact_seen,
	input  wire logic                  primary_seen,
	input  wire logic                  secondary_seen,
	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       normal_opmode,
	output logic                       contact_detect_on,
	output logic                       primary_detect_on,
	output logic                       secondary_detect_on,
	output logic [1:0]                 charger_kind,
	output logic                       detect_done,
	output logic                       busy_res
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_d;
	result_t res_s2;
	logic    valid_s2;
	logic    advance;
	logic    accept;

	// stage 1 moves on when the result register is empty or being drained
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	ucd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{mode: mode, contact_seen: contact_seen,
				primary_seen: primary_seen, secondary_seen: secondary_seen};
		end
	end

	// sequencer state commits only when its result is captured
	ucd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res_d)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid           = valid_s2;
	assign normal_opmode       = res_s2.en.normal;
	assign contact_detect_on   = res_s2.en.contact;
	assign primary_detect_on   = res_s2.en.primary;
	assign secondary_detect_on = res_s2.en.secondary;
	assign charger_kind        = res_s2.charger_kind;
	assign detect_done         = res_s2.detect_done;
	assign busy_res            = res_s2.busy_res;

	// at most one PHY mode enabled at a time
	`UCD_ASSERT_NOW(a_one_enable, valid_s2,
		$onehot0({normal_opmode, contact_detect_on, primary_detect_on, secondary_detect_on}),
		"more than one PHY control enabled")
	// done comes with a kind, PHY back to normal, not busy
	`UCD_ASSERT_NOW(a_done_clean, valid_s2 && detect_done,
		(charger_kind != KIND_NONE) && normal_opmode && !busy_res,
		"detection finished in an inconsistent state")
	// a stalled stage 1 means the result register is full and held
	`UCD_ASSERT_NOW(a_stall_cause, in_stall, valid_s2 && out_stall,
		"input stalled without a held result")

endmodule

`default_nettype wire
